// ----- rtl/lintp_pkg.sv -----
// ----------------------------------------------------------------------------
// lintp_pkg
// Shared types, constants and helpers of the LIN transport receive core.
// ----------------------------------------------------------------------------
package lintp_pkg;

  localparam int unsigned MAX_RESULTS = 8;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned IDX_W       = $clog2(MAX_RESULTS);

  localparam logic [11:0] MAX_MESSAGE_BYTES = 12'd4095;

  localparam logic [2:0] CFG_NAD_0   = 3'd0;
  localparam logic [2:0] CFG_NAD_1   = 3'd1;
  localparam logic [2:0] CFG_NAD_2   = 3'd2;
  localparam logic [2:0] CFG_NAD_3   = 3'd3;
  localparam logic [2:0] CFG_TIMEOUT = 3'd4;

  localparam logic [6:0] NAD_0_RST   = 7'd1;
  localparam logic [6:0] NAD_1_RST   = 7'd2;
  localparam logic [6:0] NAD_2_RST   = 7'd3;
  localparam logic [6:0] NAD_3_RST   = 7'd4;
  localparam logic [7:0] TIMEOUT_RST = 8'd200;

  localparam logic [7:0] NAD_FUNCTIONAL = 8'h7E;
  localparam logic [7:0] NAD_BROADCAST  = 8'h7F;

  localparam logic [3:0] PCI_SF = 4'h0;
  localparam logic [3:0] PCI_FF = 4'h1;
  localparam logic [3:0] PCI_CF = 4'h2;

  localparam logic [3:0] SF_MAX_LEN = 4'd6;
  localparam logic [2:0] FF_MAX_COPY = 3'd5;
  localparam logic [2:0] CF_MAX_COPY = 3'd6;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    RK_START = 2'd0,
    RK_DATA  = 2'd1,
    RK_OK    = 2'd2,
    RK_FAIL  = 2'd3
  } res_kind_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  node_addr;
    logic [7:0]  pci_byte;
    logic [47:0] frame_payload;
    logic        channel;
    logic        tx_busy;
  } item_t;

  typedef struct packed {
    logic [3:0][6:0] nad;
    logic [7:0]      timeout;
  } cfg_t;

  typedef struct packed {
    res_kind_t   kind;
    logic        ch;
    logic [11:0] value;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    res_t [MAX_RESULTS-1:0]      ent;
  } res_list_t;

  function automatic logic [7:0] pl_byte(input logic [47:0] pl, input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = pl[7:0];
      3'd1:    b = pl[15:8];
      3'd2:    b = pl[23:16];
      3'd3:    b = pl[31:24];
      3'd4:    b = pl[39:32];
      3'd5:    b = pl[47:40];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/lintp_cfg.sv -----
// ----------------------------------------------------------------------------
// lintp_cfg
// Configuration registers: four node addresses and the gap timeout.
// ----------------------------------------------------------------------------
module lintp_cfg import lintp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output cfg_t       cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nad[0]  <= NAD_0_RST;
      cfg_r.nad[1]  <= NAD_1_RST;
      cfg_r.nad[2]  <= NAD_2_RST;
      cfg_r.nad[3]  <= NAD_3_RST;
      cfg_r.timeout <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NAD_0:   cfg_r.nad[0]  <= cfg_wdata[6:0];
        CFG_NAD_1:   cfg_r.nad[1]  <= cfg_wdata[6:0];
        CFG_NAD_2:   cfg_r.nad[2]  <= cfg_wdata[6:0];
        CFG_NAD_3:   cfg_r.nad[3]  <= cfg_wdata[6:0];
        CFG_TIMEOUT: cfg_r.timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/lintp_in_reg.sv -----
// ----------------------------------------------------------------------------
// lintp_in_reg
// Input register: holds one transaction until the decoder takes it.
// ----------------------------------------------------------------------------
module lintp_in_reg import lintp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  advance,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  item_t item_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ----- rtl/lintp_decode.sv -----
// ----------------------------------------------------------------------------
// lintp_decode
// Address filter, reassembly state and result list for one transaction.
// ----------------------------------------------------------------------------
module lintp_decode import lintp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  item_t     item,
  input  cfg_t      cfg,
  output res_list_t list
);

  logic        rx_r,     rx_nxt;
  logic [11:0] exp_r,    exp_nxt;
  logic [11:0] rcv_r,    rcv_nxt;
  logic [3:0]  seq_r,    seq_nxt;
  logic        msg_ch_r, msg_ch_nxt;
  logic [7:0]  gap_r,    gap_nxt;

  logic [3:0]  ptype;
  logic [3:0]  low;
  logic [11:0] total;
  logic        configured;
  logic        diag;
  logic        addr_ok;
  logic [11:0] rem;
  logic [2:0]  cf_copy;
  logic [11:0] rcv_sum;

  logic        has_start;
  logic [11:0] start_val;
  logic        ch_sel;
  logic [2:0]  d0;
  logic [2:0]  copy;
  logic        has_end;
  res_kind_t   end_kind;

  always_comb begin
    ptype = item.pci_byte[7:4];
    low   = item.pci_byte[3:0];
    total = {low, item.frame_payload[7:0]};
    configured = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (item.node_addr == {1'b0, cfg.nad[i]}) configured = 1'b1;
    end
    diag    = (item.node_addr == NAD_FUNCTIONAL) || (item.node_addr == NAD_BROADCAST);
    addr_ok = (configured || diag) && !(diag && (ptype != PCI_SF));
    rem     = (exp_r > rcv_r) ? (exp_r - rcv_r) : 12'd0;
    cf_copy = (rem > {9'd0, CF_MAX_COPY}) ? CF_MAX_COPY : rem[2:0];
    rcv_sum = rcv_r + {9'd0, cf_copy};
  end

  always_comb begin
    rx_nxt     = rx_r;
    exp_nxt    = exp_r;
    rcv_nxt    = rcv_r;
    seq_nxt    = seq_r;
    msg_ch_nxt = msg_ch_r;
    gap_nxt    = gap_r;
    has_start  = 1'b0;
    start_val  = 12'd0;
    ch_sel     = msg_ch_r;
    d0         = 3'd0;
    copy       = 3'd0;
    has_end    = 1'b0;
    end_kind   = RK_OK;
    if (item.kind == KIND_TICK) begin
      if (rx_r) begin
        if (gap_r != 8'd0) begin
          gap_nxt = gap_r - 8'd1;
        end else begin
          has_end  = 1'b1;
          end_kind = RK_FAIL;
          rx_nxt   = 1'b0;
        end
      end
    end else if (addr_ok) begin
      case (ptype)
        PCI_SF: begin
          if (!rx_r && !item.tx_busy && (low != 4'd0) && (low <= SF_MAX_LEN)) begin
            has_start = 1'b1;
            start_val = {8'd0, low};
            ch_sel    = item.channel;
            copy      = low[2:0];
            has_end   = 1'b1;
          end
        end
        PCI_FF: begin
          if (!rx_r && !item.tx_busy && (total != 12'd0) && (total <= MAX_MESSAGE_BYTES)) begin
            has_start  = 1'b1;
            start_val  = total;
            ch_sel     = item.channel;
            d0         = 3'd1;
            copy       = (total > {9'd0, FF_MAX_COPY}) ? FF_MAX_COPY : total[2:0];
            exp_nxt    = total;
            rcv_nxt    = {9'd0, copy};
            seq_nxt    = 4'd1;
            msg_ch_nxt = item.channel;
            rx_nxt     = 1'b1;
            gap_nxt    = cfg.timeout;
          end
        end
        PCI_CF: begin
          if (rx_r) begin
            if (low != seq_r) begin
              has_end  = 1'b1;
              end_kind = RK_FAIL;
              rx_nxt   = 1'b0;
            end else begin
              copy    = cf_copy;
              rcv_nxt = rcv_sum;
              seq_nxt = seq_r + 4'd1;
              gap_nxt = cfg.timeout;
              if (rcv_sum >= exp_r) begin
                has_end = 1'b1;
                rx_nxt  = 1'b0;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result list: optional start record, data bytes, optional end record
  always_comb begin
    logic [3:0] k;
    list.cnt = {3'd0, has_start} + {1'b0, copy} + {3'd0, has_end};
    for (int j = 0; j < MAX_RESULTS; j++) begin
      k = 4'(j) - {3'd0, has_start};
      list.ent[j].ch = ch_sel;
      if (has_start && (j == 0)) begin
        list.ent[j].kind  = RK_START;
        list.ent[j].value = start_val;
      end else if (k < {1'b0, copy}) begin
        list.ent[j].kind  = RK_DATA;
        list.ent[j].value = {4'd0, pl_byte(item.frame_payload, d0 + k[2:0])};
      end else begin
        list.ent[j].kind  = end_kind;
        list.ent[j].value = 12'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_r     <= 1'b0;
      exp_r    <= 12'd0;
      rcv_r    <= 12'd0;
      seq_r    <= 4'd0;
      msg_ch_r <= 1'b0;
      gap_r    <= 8'd0;
    end else if (advance) begin
      rx_r     <= rx_nxt;
      exp_r    <= exp_nxt;
      rcv_r    <= rcv_nxt;
      seq_r    <= seq_nxt;
      msg_ch_r <= msg_ch_nxt;
      gap_r    <= gap_nxt;
    end
  end

endmodule

// ----- rtl/lintp_out_buf.sv -----
// ----------------------------------------------------------------------------
// lintp_out_buf
// Result register: holds the result list of one transaction and hands out
// one result per output transaction.
// ----------------------------------------------------------------------------
module lintp_out_buf import lintp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  res_list_t   list,
  output logic        load_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic        out_result_channel,
  output logic [11:0] out_result_value,
  output logic        out_last
);

  logic [CNT_W-1:0]       cnt_r;
  logic [IDX_W-1:0]       idx_r;
  res_t [MAX_RESULTS-1:0] ent_r;
  res_t                   cur;
  logic                   is_last;

  assign cur     = ent_r[idx_r];
  assign is_last = ({{(CNT_W-IDX_W){1'b0}}, idx_r} + CNT_W'(1)) == cnt_r;

  assign out_valid          = (cnt_r != '0);
  assign out_result_kind    = cur.kind;
  assign out_result_channel = cur.ch;
  assign out_result_value   = cur.value;
  assign out_last           = is_last;

  assign load_ok = !out_valid || (out_ready && is_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (load) begin
      cnt_r <= list.cnt;
      idx_r <= '0;
    end else if (out_valid && out_ready) begin
      if (is_last) begin
        cnt_r <= '0;
        idx_r <= '0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= list.ent;
    end
  end

endmodule

// ----- rtl/lin_tp_receive_reassembly_core.sv -----
// ----------------------------------------------------------------------------
// lin_tp_receive_reassembly_core
// LIN transport layer receiver: address filter and message reassembly.
// ----------------------------------------------------------------------------
// Input channel (in_*): one transaction is a received 8-byte diagnostic frame
// or one timer tick (in_kind). Output channel (out_*): zero to eight results
// per input transaction - start record with length, data bytes, then ok or
// failed - with out_last on the final result of each input transaction.
// Configuration (cfg_*): node addresses 0..3 and the gap timeout; the user
// must write them only while the block is idle, which it does not enforce.
// A transaction is accepted into the input register, decoded from there and
// loaded into the result register once that register is empty or its last
// result is being taken; the result register then shows its first result.
// Results leave one per cycle while out_ready is high; transactions that give
// no result pass at one per cycle while the result register is empty. A new
// input transaction is taken while the last result of the previous one is
// taken.
// Reset clears the input and result registers and the reassembly state and
// loads the default addresses 1..4 and a timeout of 200 ticks.
// When the receiver stalls, the current result holds and, once the input
// register is full, in_ready drops.
// ----------------------------------------------------------------------------
module lin_tp_receive_reassembly_core import lintp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_kind,
  input  logic [7:0]  in_node_addr,
  input  logic [7:0]  in_pci_byte,
  input  logic [47:0] in_frame_payload,
  input  logic        in_channel,
  input  logic        in_tx_busy,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic        out_result_channel,
  output logic [11:0] out_result_value,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  item_t     in_item;
  item_t     item;
  logic      item_valid;
  logic      load_ok;
  logic      advance;
  cfg_t      cfg;
  res_list_t list;

  assign in_item.kind          = in_kind;
  assign in_item.node_addr     = in_node_addr;
  assign in_item.pci_byte      = in_pci_byte;
  assign in_item.frame_payload = in_frame_payload;
  assign in_item.channel       = in_channel;
  assign in_item.tx_busy       = in_tx_busy;

  assign advance = item_valid && load_ok;

  lintp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lintp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lintp_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .list    (list)
  );

  lintp_out_buf u_out_buf (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (advance),
    .list               (list),
    .load_ok            (load_ok),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_result_channel (out_result_channel),
    .out_result_value   (out_result_value),
    .out_last           (out_last)
  );

endmodule

// ----- rtl/lintp_checker.sv -----
// ----------------------------------------------------------------------------
// lintp_checker
// Port-level checks of the LIN transport receive core, bound to the top.
// ----------------------------------------------------------------------------
module lintp_checker import lintp_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_result_kind,
  input logic        out_result_channel,
  input logic [11:0] out_result_value,
  input logic        out_last
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_kind) &&
      $stable(out_result_channel) && $stable(out_result_value) && $stable(out_last))
    else $error("result changed while stalled");

  // reset empties both registers
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("registers not empty after reset");

  // ok and failed always close the transaction's results
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_OK || out_result_kind == RK_FAIL) |-> out_last)
    else $error("end record not marked last");

  // a start record is always followed by data
  a_start_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_START) |-> !out_last)
    else $error("start record marked last");

  // data bytes carry eight bits only
  a_data_width: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_kind == RK_DATA) |-> (out_result_value[11:8] == 4'd0))
    else $error("data value above one byte");

endmodule

bind lin_tp_receive_reassembly_core lintp_checker u_lintp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_kind    (out_result_kind),
  .out_result_channel (out_result_channel),
  .out_result_value   (out_result_value),
  .out_last           (out_last)
);
